FILE: hdl/adnp_pkg.sv
// ----------------------------------------------------------------------------
// adnp_pkg
// shared types, constants and tables for the ascii decimal number parser
// ----------------------------------------------------------------------------
`default_nettype none

package adnp_pkg;

  // line length and output scaling
  localparam int LINE_LIMIT = 6;
  localparam int FRAC_BITS  = 16;

  // accumulator and field widths
  localparam int CNT_W   = $clog2(LINE_LIMIT);
  localparam int INT_W   = 17;
  localparam int FRAC_W  = 14;
  localparam int FDIG_W  = 3;
  localparam int VALUE_W = 34;
  localparam int MAG_W   = INT_W + FRAC_BITS;
  localparam int RECIP_W = FRAC_BITS + 11;
  localparam int PROD1_W = FRAC_W + RECIP_W;
  localparam int PROD2_W = FRAC_BITS + FRAC_W;

  localparam logic [FDIG_W-1:0] FRAC_DIG_MAX = 3'd4;
  localparam logic [20:0]       INT_ACC_MAX  = 21'd131071;
  localparam logic [63:0]       MAG_MAX      = 64'h1_FFFF_FFFF;

  // character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // floor(2^(FRAC_BITS+14) / 10^k)
  localparam logic [63:0] RECIP_1 = (64'd1 << (FRAC_BITS + FRAC_W)) / 64'd10;
  localparam logic [63:0] RECIP_2 = (64'd1 << (FRAC_BITS + FRAC_W)) / 64'd100;
  localparam logic [63:0] RECIP_3 = (64'd1 << (FRAC_BITS + FRAC_W)) / 64'd1000;
  localparam logic [63:0] RECIP_4 = (64'd1 << (FRAC_BITS + FRAC_W)) / 64'd10000;

  // finished line handed to the scaling pipeline
  typedef struct packed {
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [FDIG_W-1:0] frac_dig;
    logic              negative;
    logic              err;
  } line_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [FDIG_W-1:0] dig);
    logic [RECIP_W-1:0] r;
    case (dig)
      3'd1:    r = RECIP_1[RECIP_W-1:0];
      3'd2:    r = RECIP_2[RECIP_W-1:0];
      3'd3:    r = RECIP_3[RECIP_W-1:0];
      3'd4:    r = RECIP_4[RECIP_W-1:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [FDIG_W-1:0] dig);
    logic [FRAC_W-1:0] p;
    case (dig)
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/adnp_parser.sv
// ----------------------------------------------------------------------------
// adnp_parser
// input register and per-character parse state; emits a line record on newline
// ----------------------------------------------------------------------------
`default_nettype none

module adnp_parser import adnp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        snap_valid,
  input  logic        snap_ready,
  output line_t       snap
);

  logic             i_valid;
  logic [7:0]       i_char;

  logic [INT_W-1:0]  int_acc, int_acc_next;
  logic [FRAC_W-1:0] frac_acc, frac_acc_next;
  logic [FDIG_W-1:0] frac_dig, frac_dig_next;
  logic              in_frac, in_frac_next;
  logic              negative, negative_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              line_ok, line_ok_next;
  logic              point_ok, point_ok_next;
  logic              sign_ok, sign_ok_next;

  logic              is_nl, is_digit, is_point;
  logic [3:0]        digit;
  logic [20:0]       int_ten;
  logic [FRAC_W-1:0] frac_ten;
  logic              snap_free, i_move;

  assign is_nl    = (i_char == CH_NL);
  assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
  assign is_point = (i_char == CH_DOT) || (i_char == CH_COMMA);
  assign digit    = i_char[3:0];
  assign int_ten  = {4'b0, int_acc} * 21'd10 + {17'b0, digit};
  assign frac_ten = frac_acc * 14'd10 + {10'b0, digit};

  assign snap_free = !snap_valid || snap_ready;
  assign i_move    = i_valid && (!is_nl || snap_free);
  assign in_ready  = !i_valid || i_move;

  always_comb begin
    int_acc_next  = int_acc;
    frac_acc_next = frac_acc;
    frac_dig_next = frac_dig;
    in_frac_next  = in_frac;
    negative_next = negative;
    cnt_next      = cnt;
    line_ok_next  = line_ok;
    point_ok_next = point_ok;
    sign_ok_next  = sign_ok;
    if (i_move) begin
      if (is_nl) begin
        int_acc_next  = '0;
        frac_acc_next = '0;
        frac_dig_next = '0;
        in_frac_next  = 1'b0;
        negative_next = 1'b0;
        cnt_next      = '0;
        line_ok_next  = 1'b1;
        point_ok_next = 1'b1;
        sign_ok_next  = 1'b1;
      end else if (i_char == CH_MINUS && cnt == '0 && sign_ok) begin
        negative_next = 1'b1;
        sign_ok_next  = 1'b0;
        cnt_next      = cnt + CNT_W'(1);
      end else if (cnt < CNT_W'(LINE_LIMIT - 1)) begin
        if (is_point && point_ok && cnt != '0) begin
          in_frac_next  = 1'b1;
          point_ok_next = 1'b0;
          cnt_next      = cnt + CNT_W'(1);
        end else if (is_digit) begin
          if (!in_frac) begin
            int_acc_next = (int_ten > INT_ACC_MAX) ? '1 : int_ten[INT_W-1:0];
          end else if (frac_dig < FRAC_DIG_MAX) begin
            frac_acc_next = frac_ten;
            frac_dig_next = frac_dig + FDIG_W'(1);
          end
          cnt_next = cnt + CNT_W'(1);
        end else begin
          line_ok_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid    <= 1'b0;
      snap_valid <= 1'b0;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_dig   <= '0;
      in_frac    <= 1'b0;
      negative   <= 1'b0;
      cnt        <= '0;
      line_ok    <= 1'b1;
      point_ok   <= 1'b1;
      sign_ok    <= 1'b1;
    end else begin
      if (in_ready) begin
        i_valid <= in_valid;
      end
      if (i_move && is_nl) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      int_acc  <= int_acc_next;
      frac_acc <= frac_acc_next;
      frac_dig <= frac_dig_next;
      in_frac  <= in_frac_next;
      negative <= negative_next;
      cnt      <= cnt_next;
      line_ok  <= line_ok_next;
      point_ok <= point_ok_next;
      sign_ok  <= sign_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_char <= char_in;
    end
    if (i_move && is_nl) begin
      snap.int_acc  <= int_acc;
      snap.frac_acc <= frac_acc;
      snap.frac_dig <= frac_dig;
      snap.negative <= negative;
      snap.err      <= !line_ok;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/adnp_scale.sv
// ----------------------------------------------------------------------------
// adnp_scale
// fraction to binary by reciprocal multiply with one-step correction,
// then merge, saturate, sign and output register
// ----------------------------------------------------------------------------
`default_nettype none

module adnp_scale import adnp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      snap_valid,
  output logic                      snap_ready,
  input  line_t                     snap,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] value_fixed,
  output logic                      status
);

  logic               b_valid;
  line_t              b_line;
  logic [PROD1_W-1:0] b_prod;

  logic                 c_valid;
  line_t                c_line;
  logic [FRAC_BITS-1:0] c_q0;
  logic [PROD2_W-1:0]   c_prod;

  logic                 o_free, c_move, c_free, b_move, b_free;
  logic [FRAC_BITS-1:0] q0;
  logic [PROD2_W-1:0]   scaled, rem, pdiv;
  logic                 corr;
  logic [FRAC_BITS-1:0] q;
  logic [MAG_W-1:0]     mag;
  logic [63:0]          mag_ext;
  logic [VALUE_W-1:0]   mag_sat, val;

  assign o_free     = !out_valid || out_ready;
  assign c_move     = c_valid && o_free;
  assign c_free     = !c_valid || c_move;
  assign b_move     = b_valid && c_free;
  assign b_free     = !b_valid || b_move;
  assign snap_ready = b_free;

  // first guess, at most one below the true quotient
  assign q0 = b_prod[FRAC_W +: FRAC_BITS];

  // remainder check and final value
  assign scaled  = {c_line.frac_acc, {FRAC_BITS{1'b0}}};
  assign pdiv    = PROD2_W'(pow10(c_line.frac_dig));
  assign rem     = scaled - c_prod;
  assign corr    = (rem >= pdiv);
  assign q       = c_q0 + FRAC_BITS'(corr);
  assign mag     = {c_line.int_acc, q};
  assign mag_ext = 64'(mag);
  assign mag_sat = (mag_ext > MAG_MAX) ? MAG_MAX[VALUE_W-1:0] : mag_ext[VALUE_W-1:0];
  assign val     = c_line.err ? '0 : (c_line.negative ? (~mag_sat + VALUE_W'(1)) : mag_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid <= snap_valid;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
      if (o_free) begin
        out_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && b_free) begin
      b_line <= snap;
      b_prod <= PROD1_W'(snap.frac_acc) * PROD1_W'(recip(snap.frac_dig));
    end
    if (b_move) begin
      c_line <= b_line;
      c_q0   <= q0;
      c_prod <= PROD2_W'(q0) * PROD2_W'(pow10(b_line.frac_dig));
    end
    if (c_move) begin
      value_fixed <= val;
      status      <= c_line.err;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ascii_decimal_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// ascii characters in, signed fixed-point number out, one result per line
// ----------------------------------------------------------------------------
// Takes one character item per cycle and builds a signed decimal number: a
// leading minus, integer digits, one '.' or ',' and fraction digits, with at
// most LINE_LIMIT-1 characters counted and later ones dropped. A newline ends
// the line and gives one result item: value_fixed is the number times
// 2^FRAC_BITS, truncated toward zero, saturated at magnitude 2^33-1, and
// status is 1 (with value zero) if the line held an invalid character. The
// block sustains one character every cycle; only a stalled output can stall
// the input. A newline's result reaches out_valid through the input register,
// parse and line capture, the fraction-times-reciprocal multiplier, the
// quotient-times-divisor check multiplier, and the output register, each
// one stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_decimal_number_parser import adnp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                char_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] value_fixed,
  output logic                      status
);

  // finished line between parser and scaling pipeline
  logic  snap_valid;
  logic  snap_ready;
  line_t snap;

  // character parsing and per-line state
  adnp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // fraction conversion, sign and output register
  adnp_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_fixed (value_fixed),
    .status      (status)
  );

  // an error line always reports zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> value_fixed == '0)
    else $error("error line with nonzero value");

  // with the output stage empty nothing may hold back the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // saturation keeps the magnitude below 2^33
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value_fixed != {1'b1, {(VALUE_W-1){1'b0}}})
    else $error("value beyond saturation range");

  // a line record waits only while the scaling pipeline is full
  assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_ready |-> out_valid && !out_ready)
    else $error("line record stalled without output backpressure");

endmodule

`default_nettype wire

FILE: dv/ascii_decimal_number_parser_test.sv
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_test
// self-checking bench for the ascii decimal number parser
// ----------------------------------------------------------------------------
// Feeds character items over the input channel. A line scoreboard tracks the
// parse state of the line in progress and, on every newline, works out the
// fixed-point value and status that the block should return. Each result
// item is checked field by field against the oldest expected one. Starts
// with a few hand-picked lines, then runs random lines through phases with
// no idling, a mostly idle sender, a mostly stalled receiver, and light
// idling on both sides. One long receiver hold-off backs the block up until
// it stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_decimal_number_parser_test import adnp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake before the run is declared hung
  localparam int QUIET_LIMIT    = 4000;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES    = 300;
  // character items per random phase
  localparam int PHASE_ITEMS    = 300;
  // cycles to wait after the last result, well past the pipeline depth
  localparam int DRAIN_CYCLES   = 16;

  // --------------------------------------------------------------------------
  // line scoreboard: tracks the line being parsed and the results it owes
  // --------------------------------------------------------------------------
  class line_scoreboard;
    bit [INT_W-1:0]  int_acc;
    bit [FRAC_W-1:0] frac_acc;
    bit [FDIG_W-1:0] frac_dig;
    bit              in_frac;
    bit              minus_seen;
    bit [3:0]        count;
    bit              line_ok;
    bit              point_ok;
    bit              sign_ok;

    // expected result items, oldest first
    logic signed [VALUE_W-1:0] value_q[$];
    bit                        status_q[$];
    int                        mismatches;

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      int_acc    = '0;
      frac_acc   = '0;
      frac_dig   = '0;
      in_frac    = 1'b0;
      minus_seen = 1'b0;
      count      = '0;
      line_ok    = 1'b1;
      point_ok   = 1'b1;
      sign_ok    = 1'b1;
    endfunction

    // accepted character item: advance the parse, queue a result on newline
    function void note_char(bit [7:0] c);
      logic [63:0] mag;
      logic [63:0] scale;
      int unsigned acc;
      if (c == CH_NL) begin
        if (line_ok) begin
          // divide by ten to the number of fraction digits held
          case ((frac_dig > FRAC_DIG_MAX) ? FRAC_DIG_MAX : frac_dig)
            3'd1:    scale = 64'd10;
            3'd2:    scale = 64'd100;
            3'd3:    scale = 64'd1000;
            3'd4:    scale = 64'd10000;
            default: scale = 64'd1;
          endcase
          mag = (64'(int_acc) << FRAC_BITS) + ((64'(frac_acc) << FRAC_BITS) / scale);
          if (mag > MAG_MAX) mag = MAG_MAX;
          if (minus_seen) mag = 64'd0 - mag;
          value_q.push_back(mag[VALUE_W-1:0]);
          status_q.push_back(1'b0);
        end else begin
          value_q.push_back('0);
          status_q.push_back(1'b1);
        end
        clear_line();
      end else if (c == CH_MINUS && count == 0 && sign_ok) begin
        minus_seen = 1'b1;
        sign_ok    = 1'b0;
        count++;
      end else if (count < LINE_LIMIT - 1) begin
        if ((c == CH_DOT || c == CH_COMMA) && point_ok && count != 0) begin
          in_frac  = 1'b1;
          point_ok = 1'b0;
          count++;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          if (!in_frac) begin
            acc = int_acc * 10 + (c - CH_ZERO);
            int_acc = (acc > INT_ACC_MAX) ? INT_ACC_MAX[INT_W-1:0] : acc[INT_W-1:0];
          end else if (frac_dig < FRAC_DIG_MAX) begin
            frac_acc = FRAC_W'(frac_acc * 10 + (c - CH_ZERO));
            frac_dig++;
          end
          count++;
        end else begin
          line_ok = 1'b0;
        end
      end
      // once the line is full, other characters fall through untouched
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // accepted result item: compare with the oldest expectation
    task check_result(logic signed [VALUE_W-1:0] value, logic stat);
      logic signed [VALUE_W-1:0] want_value;
      bit                        want_status;
      if (value_q.size() == 0) begin
        flag_mismatch($sformatf("result value %0d status %0b with nothing expected",
                                value, stat));
      end else begin
        want_value  = value_q.pop_front();
        want_status = status_q.pop_front();
        if (value !== want_value)
          flag_mismatch($sformatf("value_fixed %0d, expected %0d", value, want_value));
        if (stat !== want_status)
          flag_mismatch($sformatf("status %0b, expected %0b", stat, want_status));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [7:0]                char_in   = 8'd0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value_fixed;
  logic                      status;

  always #4ns clk = ~clk;

  ascii_decimal_number_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_fixed(value_fixed),
    .status     (status)
  );

  line_scoreboard board = new();

  // idling controls, in percent of cycles
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // long hold-off request, picked up by the receiver process
  bit hold_go    = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;

  // characters of the next random line
  bit [7:0] line_chars[$];

  // --------------------------------------------------------------------------
  // receiver: random stalls plus one counted hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      // keep out_ready low so the pipeline backs up into in_ready
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every handshake is seen here at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_char(char_in);
      if (out_valid && out_ready) board.check_result(value_fixed, status);
    end
  end

  // watchdog: any accepted item on either side resets the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks, entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_char(bit [7:0] c);
    // random gap before the item, with junk on the bus while idle
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      char_in  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    // hold valid and payload until the handshake
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // one random line: mostly well formed, some broken, some plain noise
  function automatic void build_line();
    int unsigned kind;
    int unsigned pos;
    line_chars.delete();
    kind = $urandom_range(99);
    if (kind < 85) begin
      if ($urandom_range(1)) line_chars.push_back(CH_MINUS);
      repeat ($urandom_range(5)) line_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(1)) begin
        line_chars.push_back($urandom_range(1) ? CH_DOT : CH_COMMA);
        repeat ($urandom_range(4)) line_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      // broken line: one character swapped for a stray byte, minus or point
      if (kind >= 70 && line_chars.size() > 0) begin
        pos = $urandom_range(line_chars.size() - 1);
        case ($urandom_range(2))
          0:       line_chars[pos] = 8'($urandom_range(255));
          1:       line_chars[pos] = CH_MINUS;
          default: line_chars[pos] = CH_DOT;
        endcase
      end
    end else begin
      repeat ($urandom_range(8, 1)) line_chars.push_back(8'($urandom_range(255)));
    end
    line_chars.push_back(CH_NL);
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int sent;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed lines
    send_text("\n");       // empty line
    send_text("-0\n");     // minus zero
    send_text("99999z\n"); // largest integer, line full so the letter is ignored
    send_text("1,2.\n");   // comma as point, then a second point
    send_text(".5\n");     // point before any counted character
    // misplaced minus, then the lowest and highest bytes
    send_char(CH_ZERO + 8'd1);
    send_char(CH_MINUS);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NL);

    // random phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_go   = 1'b1; // fill the block while the sender keeps going
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 22;
          stall_pct = 22;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_line();
        foreach (line_chars[i]) send_char(line_chars[i]);
        sent += line_chars.size();
      end
    end

    in_valid <= 1'b0;

    // drain the results still owed, then let the pipeline settle
    while (board.value_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.value_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
